// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
// Both expect a clock named clk; the first also expects a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is off while reset is high
`define CHK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that holds at every edge, reset included
`define CHK_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/doy_pkg.sv =====
// Shared constants, types and the year-length function for the date unit.
// No dependencies; used by doy_alu, doy_seq and the top level.
`timescale 1ns / 1ps

package doy_pkg;

  localparam int DELTA_W = 16;               // day count bits actually used
  localparam int ACC_W   = ((DELTA_W > 15) ? DELTA_W : 15) + 2;  // signed day accumulator
  localparam int YR_W    = 18;               // signed working year
  localparam int YEAR_W  = 14;
  localparam int DAY_W   = 9;
  localparam int DIN_W   = 16;               // day count field on the bus
  localparam int LEN_W   = 9;

  localparam int YEAR_MIN    = 1;
  localparam int YEAR_MAX    = 9999;
  localparam int DAYS_COMMON = 365;
  localparam int DAYS_LEAP   = 366;
  localparam int CYCLE_YRS   = 400;          // Gregorian cycle
  localparam int MOD_STEPS   = 6;            // 400 << 5 down to 400 << 0
  localparam int K_W         = 3;

  typedef struct packed {
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic                    sub;
  } alu_req_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic                    neg;
    logic                    zero;
  } alu_res_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [DAY_W-1:0]  day;
    logic              oor;
  } doy_res_t;

  // r is the year modulo 400, 0..399
  function automatic logic [LEN_W-1:0] year_len(input logic [YEAR_W-1:0] r);
    logic leap;
    leap = (r == '0) ||
           ((r[1:0] == 2'b00) && (r != YEAR_W'(100)) && (r != YEAR_W'(200)) &&
            (r != YEAR_W'(300)));
    return leap ? LEN_W'(DAYS_LEAP) : LEN_W'(DAYS_COMMON);
  endfunction

endpackage

// ===== hw/rtl/doy_alu.sv =====
// Shared add/subtract unit with sign and zero flags.
// Depends on doy_pkg for the request and result structs.
`timescale 1ns / 1ps

module doy_alu (
  input  doy_pkg::alu_req_t req,
  output doy_pkg::alu_res_t res
);
  import doy_pkg::*;

  logic signed [ACC_W-1:0] b_op;

  always_comb begin
    b_op     = req.sub ? ~req.b : req.b;
    res.sum  = req.a + b_op + ACC_W'(req.sub);
    res.neg  = res.sum[ACC_W-1];
    res.zero = (res.sum == '0);
  end

endmodule

// ===== hw/rtl/doy_seq.sv =====
// Sequencer: reduces the year modulo 400, then steps the year forward and
// backward one per cycle through the shared adder. Depends on doy_pkg, doy_alu.
`timescale 1ns / 1ps

module doy_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      mode,
  input  logic [doy_pkg::YEAR_W-1:0] in_year,
  input  logic [doy_pkg::DAY_W-1:0]  in_day,
  input  logic [doy_pkg::DIN_W-1:0]  delta_days,
  input  logic                      take,
  output logic                      idle,
  output logic                      done,
  output doy_pkg::doy_res_t         res
);
  import doy_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_FWD  = 3'd2;
  localparam logic [2:0] S_BWD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic signed [YR_W-1:0] YMAX_S = YR_W'(YEAR_MAX);
  localparam logic signed [YR_W-1:0] YMIN_S = YR_W'(YEAR_MIN);

  logic [2:0]              state;
  logic [K_W-1:0]          k;
  logic [YEAR_W-1:0]       rem;    // year mod 400 once reduced
  logic signed [YR_W-1:0]  year;
  logic signed [ACC_W-1:0] day;

  logic [DELTA_W-1:0] dlt;
  logic [YEAR_W-1:0]  rem_inc;
  logic [YEAR_W-1:0]  rem_dec;
  logic [LEN_W-1:0]   len_cur;
  logic [LEN_W-1:0]   len_prev;
  logic               day_le0;
  alu_req_t           req;
  alu_res_t           ares;

  doy_alu u_alu (
    .req (req),
    .res (ares)
  );

  always_comb begin
    dlt      = DELTA_W'(delta_days);
    rem_inc  = (rem == YEAR_W'(CYCLE_YRS - 1)) ? '0 : rem + YEAR_W'(1);
    rem_dec  = (rem == '0) ? YEAR_W'(CYCLE_YRS - 1) : rem - YEAR_W'(1);
    len_cur  = year_len(rem);
    len_prev = year_len(rem_dec);
    day_le0  = day[ACC_W-1] || (day == '0);
  end

  always_comb begin
    req.a   = day;
    req.b   = '0;
    req.sub = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.a   = ACC_W'(in_day);
        req.b   = ACC_W'(dlt);
        req.sub = mode;
      end
      S_MOD: begin
        req.a   = ACC_W'(rem);
        req.b   = ACC_W'(CYCLE_YRS) << k;
        req.sub = 1'b1;
      end
      S_FWD: begin
        req.b   = ACC_W'(len_cur);
        req.sub = 1'b1;
      end
      S_BWD: begin
        req.b   = ACC_W'(len_prev);
      end
      default: begin
        req.b   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            day   <= ares.sum;
            rem   <= in_year;
            year  <= YR_W'(in_year);
            k     <= K_W'(MOD_STEPS - 1);
            state <= S_MOD;
          end
        end
        S_MOD: begin
          // restoring reduction: one multiple of 400 per cycle
          if (!ares.neg) rem <= ares.sum[YEAR_W-1:0];
          if (k == '0) state <= S_FWD;
          else k <= k - K_W'(1);
        end
        S_FWD: begin
          if (!ares.neg && !ares.zero) begin
            day  <= ares.sum;
            year <= year + YR_W'(1);
            rem  <= rem_inc;
          end else begin
            state <= S_BWD;
          end
        end
        S_BWD: begin
          if (day_le0) begin
            day  <= ares.sum;
            year <= year - YR_W'(1);
            rem  <= rem_dec;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

  // clamp at the range bounds
  always_comb begin
    if (year > YMAX_S) begin
      res.year = YEAR_W'(YEAR_MAX);
      res.day  = DAY_W'(DAYS_COMMON);
      res.oor  = 1'b1;
    end else if (year < YMIN_S) begin
      res.year = YEAR_W'(YEAR_MIN);
      res.day  = DAY_W'(1);
      res.oor  = 1'b1;
    end else begin
      res.year = year[YEAR_W-1:0];
      res.day  = day[DAY_W-1:0];
      res.oor  = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/day_of_year_date_add_subtract_unit.sv =====
// Top level of the day-of-year date add/subtract unit: stream ports and
// output register. Depends on doy_pkg, doy_seq and assert_macros.svh.
//
// Usage:
//   A request on s_* carries a date (year, day of year), a day count and a
//   mode bit (0 add, 1 subtract). One result leaves on m_* per request:
//   the new year and day, clamped to 1..9999 with out_of_range set when
//   the date left that span.
//   s_tready is high only while the sequencer is idle; one request is
//   worked at a time. The sequencer first reduces the start year modulo
//   400, then steps one year per cycle through the shared adder for each
//   year boundary crossed. A 16-bit count crosses at most about 180
//   years.
//   The result sits in an output register; the next request is taken
//   while it waits. If m_tready stays low, the following result waits in
//   the sequencer and s_tready stays low.
//   Reset (rst, synchronous) returns to idle and drops m_tvalid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module day_of_year_date_add_subtract_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // mode[0], in_year[14:1], in_day[23:15], delta_days[39:24]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // out_year[13:0], out_day[22:14], out_of_range[23]
);
  import doy_pkg::*;

  logic     start;
  logic     take;
  logic     idle;
  logic     done;
  doy_res_t res;
  doy_res_t out_reg;

  assign s_tready = idle;
  assign start    = s_tvalid && idle;
  assign take     = done && (!m_tvalid || m_tready);

  doy_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (s_tdata[0]),
    .in_year    (s_tdata[14:1]),
    .in_day     (s_tdata[23:15]),
    .delta_days (s_tdata[39:24]),
    .take       (take),
    .idle       (idle),
    .done       (done),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_reg <= res;
  end

  assign m_tdata = {out_reg.oor, out_reg.day, out_reg.year};

  `CHK_RST(a_busy_after_req, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")
  `CHK_RST(a_take_valid, take |=> m_tvalid, "result lost")
  `CHK_RST(a_year_rng, m_tvalid |-> (m_tdata[13:0] >= 14'd1 && m_tdata[13:0] <= 14'd9999), "year range")
  `CHK_RST(a_day_rng, m_tvalid |-> (m_tdata[22:14] != 9'd0 && m_tdata[22:14] <= 9'd366), "day range")

endmodule
